// ===== hw/rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Counter sizing, register codes and the request/result payload types.
// ----------------------------------------------------------------------------
package uer_pkg;

  // Width of the tick counters (valid range 16 to 32).
  localparam int unsigned COUNTER_BITS = 24;

  localparam int unsigned TickBits  = 24;  // width of the tick registers
  localparam int unsigned RangeBits = 12;  // width of the range registers and distance
  localparam int unsigned CfgIdxBits = 3;

  localparam longint unsigned CounterMax = (64'd1 << COUNTER_BITS) - 64'd1;
  localparam int unsigned CmDivisor = 58;
  localparam int unsigned DistMax   = 4095;

  // Quotient and remainder of the running width / 58 split.
  localparam int unsigned QuotBits = $clog2(CounterMax / CmDivisor + 1);
  localparam int unsigned RemBits  = $clog2(CmDivisor);

  // Compare widths, wide enough for both operands.
  localparam int unsigned CmpBits  = (COUNTER_BITS > TickBits) ? COUNTER_BITS : TickBits;
  localparam int unsigned QCmpBits = (QuotBits > RangeBits) ? QuotBits : RangeBits;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [TickBits-1:0]     tick_t;
  typedef logic [RangeBits-1:0]    range_t;
  typedef logic [QuotBits-1:0]     quot_t;
  typedef logic [RemBits-1:0]      rem_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TRIG_LOW  = 3'd0,
    CFG_TRIG_HIGH = 3'd1,
    CFG_TIMEOUT   = 3'd2,
    CFG_CLEAR     = 3'd3,
    CFG_MIN_RANGE = 3'd4,
    CFG_MAX_RANGE = 3'd5
  } uer_cfg_idx_e;

  typedef struct packed {
    tick_t  trigger_low_ticks;
    tick_t  trigger_high_ticks;
    tick_t  echo_timeout_ticks;
    tick_t  clear_pulse_ticks;
    range_t min_range_cm;
    range_t max_range_cm;
  } uer_cfg_t;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } uer_req_t;

  typedef struct packed {
    logic   trigger_level;
    logic   echo_clear;
    logic   measurement_done;
    range_t distance_cm;
    logic   in_range;
  } uer_res_t;

endpackage

// ===== hw/rtl/uer_if.sv =====
// ----------------------------------------------------------------------------
// uer_req_if / uer_res_if: valid/ready channels of the echo ranger
// Request channel carries one tick, result channel one tick's pin levels and distance report.
// ----------------------------------------------------------------------------
interface uer_req_if;
  import uer_pkg::*;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;

  modport source (output valid, output start_request, output echo_level, input ready);
  modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

interface uer_res_if;
  import uer_pkg::*;
  logic   valid;
  logic   ready;
  logic   trigger_level;
  logic   echo_clear;
  logic   measurement_done;
  range_t distance_cm;
  logic   in_range;

  modport source (output valid, output trigger_level, output echo_clear,
                  output measurement_done, output distance_cm, output in_range,
                  input ready);
  modport sink   (input valid, input trigger_level, input echo_clear,
                  input measurement_done, input distance_cm, input in_range,
                  output ready);
endinterface

// ===== hw/rtl/uer_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// uer_cfg_regs: configuration register file
// Write-only registers, loaded by index, reset to the default timing.
// ----------------------------------------------------------------------------
module uer_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [uer_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  uer_pkg::tick_t            cfg_data_i,
  output uer_pkg::uer_cfg_t         cfg_o
);
  import uer_pkg::*;

  uer_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (uer_cfg_idx_e'(cfg_idx_i))
        CFG_TRIG_LOW:  cfg_d.trigger_low_ticks  = cfg_data_i;
        CFG_TRIG_HIGH: cfg_d.trigger_high_ticks = cfg_data_i;
        CFG_TIMEOUT:   cfg_d.echo_timeout_ticks = cfg_data_i;
        CFG_CLEAR:     cfg_d.clear_pulse_ticks  = cfg_data_i;
        CFG_MIN_RANGE: cfg_d.min_range_cm       = cfg_data_i[RangeBits-1:0];
        CFG_MAX_RANGE: cfg_d.max_range_cm       = cfg_data_i[RangeBits-1:0];
        default:       cfg_d = cfg_q;  // unknown index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_low_ticks  <= tick_t'(5000);
      cfg_q.trigger_high_ticks <= tick_t'(20000);
      cfg_q.echo_timeout_ticks <= tick_t'(12000);
      cfg_q.clear_pulse_ticks  <= tick_t'(10000);
      cfg_q.min_range_cm       <= range_t'(2);
      cfg_q.max_range_cm       <= range_t'(200);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/uer_fsm.sv =====
// ----------------------------------------------------------------------------
// uer_fsm: measurement sequencer
// Trigger, echo wait with clear pulses, and echo width timing; one tick per step.
// ----------------------------------------------------------------------------
module uer_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  uer_pkg::uer_req_t req_i,
  input  uer_pkg::uer_cfg_t cfg_i,
  output uer_pkg::uer_res_t res_o
);
  import uer_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT      = 3'd3,
    PH_CLEAR     = 3'd4,
    PH_MEASURE   = 3'd5
  } phase_e;

  localparam cnt_t CntMax = '1;
  localparam rem_t RemLast = rem_t'(CmDivisor - 1);

  phase_e phase_q, phase_d;
  cnt_t   pc_q, pc_d, wc_q, wc_d, width_q, width_d;
  quot_t  quot_q, quot_d;
  rem_t   rem_q, rem_d;

  cnt_t   pc_inc, wc_inc;
  logic   pc_sat, wc_sat;
  logic   low_end, high_end, clr_end, timed_out;
  logic   q_in_range, q_over;

  assign pc_inc = (pc_q == CntMax) ? pc_q : pc_q + 1'b1;
  assign wc_inc = (wc_q == CntMax) ? wc_q : wc_q + 1'b1;
  assign pc_sat = (pc_inc == CntMax);
  assign wc_sat = (wc_inc == CntMax);

  // phase ends once the advanced count reaches the length (the wait once it exceeds the timeout), or saturates
  assign low_end   = (CmpBits'(pc_inc) >= CmpBits'(cfg_i.trigger_low_ticks))  || pc_sat;
  assign high_end  = (CmpBits'(pc_inc) >= CmpBits'(cfg_i.trigger_high_ticks)) || pc_sat;
  assign clr_end   = (CmpBits'(pc_inc) >= CmpBits'(cfg_i.clear_pulse_ticks))  || pc_sat;
  assign timed_out = (CmpBits'(wc_inc) >  CmpBits'(cfg_i.echo_timeout_ticks)) || wc_sat;

  // quotient is kept exact as the width grows, so no divider is needed
  assign q_over     = QCmpBits'(quot_q) > QCmpBits'(DistMax);
  assign q_in_range = (QCmpBits'(quot_q) >= QCmpBits'(cfg_i.min_range_cm)) &&
                      (QCmpBits'(quot_q) <= QCmpBits'(cfg_i.max_range_cm));

  always_comb begin
    phase_d = phase_q;
    pc_d    = pc_q;
    wc_d    = wc_q;
    width_d = width_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    res_o   = '0;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start_request) begin
          phase_d = PH_TRIG_LOW;
          pc_d    = '0;
        end
      end
      PH_TRIG_LOW: begin
        pc_d = pc_inc;
        if (low_end) begin
          phase_d = PH_TRIG_HIGH;
          pc_d    = '0;
        end
      end
      PH_TRIG_HIGH: begin
        res_o.trigger_level = 1'b1;
        pc_d = pc_inc;
        if (high_end) begin
          phase_d = PH_WAIT;
          pc_d    = '0;
          wc_d    = '0;
        end
      end
      PH_WAIT: begin
        if (req_i.echo_level) begin
          phase_d = PH_MEASURE;
          width_d = cnt_t'(1);
          quot_d  = '0;
          rem_d   = rem_t'(1);
        end else begin
          wc_d = wc_inc;
          if (timed_out) begin
            phase_d = PH_CLEAR;
            pc_d    = '0;
          end
        end
      end
      PH_CLEAR: begin
        res_o.echo_clear = 1'b1;
        wc_d = wc_inc;
        pc_d = pc_inc;
        if (clr_end) begin
          phase_d = PH_WAIT;
          pc_d    = '0;
        end
      end
      PH_MEASURE: begin
        if (req_i.echo_level) begin
          if (width_q != CntMax) begin
            width_d = width_q + 1'b1;
            if (rem_q == RemLast) begin
              rem_d  = '0;
              quot_d = quot_q + 1'b1;
            end else begin
              rem_d = rem_q + 1'b1;
            end
          end
        end else begin
          res_o.measurement_done = 1'b1;
          res_o.distance_cm      = q_over ? range_t'(DistMax) : range_t'(quot_q);
          res_o.in_range         = q_in_range;
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pc_q    <= '0;
      wc_q    <= '0;
      width_q <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pc_q    <= pc_d;
      wc_q    <= wc_d;
      width_q <= width_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: one HC-SR04 style range channel, one tick per request
// Path: a taken request is held in the request register, and its step result in the output register.
// Throughput: one request per cycle while the result sink does not stall.
// Reset: rst_ni clears both pipeline stages and returns the sequencer to idle;
//   registers return to 5000/20000/12000/10000 ticks and a 2..200 cm window.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  uer_req_if.sink                        req_i,
  uer_res_if.source                      res_o,
  input  logic                           cfg_we_i,
  input  logic [uer_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  uer_pkg::tick_t                 cfg_data_i
);
  import uer_pkg::*;

  // Pipeline: request register -> sequencer step -> result register.
  // The result register decouples the sink, so a stalled result does not
  // stop a request being captured while the request stage is free.

  uer_cfg_t cfg;
  uer_req_t in_q;
  logic     in_vld_q;
  uer_res_t out_q, step_res;
  logic     out_vld_q;

  logic advance;  // the result register can take a new entry
  logic step;     // the held request is processed this cycle

  assign advance     = !out_vld_q || res_o.ready;
  assign step        = in_vld_q && advance;
  assign req_i.ready = !in_vld_q || advance;

  uer_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer state advances only when its request moves on to the result stage
  uer_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.start_request <= req_i.start_request;
      in_q.echo_level    <= req_i.echo_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.trigger_level    = out_q.trigger_level;
  assign res_o.echo_clear       = out_q.echo_clear;
  assign res_o.measurement_done = out_q.measurement_done;
  assign res_o.distance_cm      = out_q.distance_cm;
  assign res_o.in_range         = out_q.in_range;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ultrasonic echo ranger
// Drives one microsecond tick per request and predicts the pin levels, the
// clear pulses and the distance report of every tick in a small scoreboard.
// A directed part walks the reset settings, zero and full-scale registers
// and the range window edges. Random measurements with short register
// settings follow, under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import uer_pkg::*;

  // Sequencer phases as tracked by the scoreboard.
  typedef enum int unsigned {
    SEQ_IDLE,
    SEQ_TRIG_LOW,
    SEQ_TRIG_HIGH,
    SEQ_WAIT_ECHO,
    SEQ_CLEAR,
    SEQ_MEASURE
  } tick_phase_e;

  localparam int unsigned TickMax  = (1 << TickBits) - 1;
  localparam int unsigned RangeMax = (1 << RangeBits) - 1;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and the sequencer, one expected
  // result per accepted request, checked in order.
  // --------------------------------------------------------------------------
  class range_scoreboard;
    uer_cfg_t    regs;
    tick_phase_e phase;
    cnt_t        phase_cnt;
    cnt_t        wait_cnt;
    cnt_t        width_cnt;
    uer_res_t    expected_pins[$];
    int unsigned mismatches;
    int unsigned ticks_seen;
    int unsigned ranges_done;
    int unsigned clear_ticks;

    function new();
      regs.trigger_low_ticks  = 24'd5000;
      regs.trigger_high_ticks = 24'd20000;
      regs.echo_timeout_ticks = 24'd12000;
      regs.clear_pulse_ticks  = 24'd10000;
      regs.min_range_cm       = 12'd2;
      regs.max_range_cm       = 12'd200;
      phase       = SEQ_IDLE;
      phase_cnt   = '0;
      wait_cnt    = '0;
      width_cnt   = '0;
      mismatches  = 0;
      ticks_seen  = 0;
      ranges_done = 0;
      clear_ticks = 0;
    endfunction

    function void write_reg(uer_cfg_idx_e idx, tick_t value);
      case (idx)
        CFG_TRIG_LOW:  regs.trigger_low_ticks  = value;
        CFG_TRIG_HIGH: regs.trigger_high_ticks = value;
        CFG_TIMEOUT:   regs.echo_timeout_ticks = value;
        CFG_CLEAR:     regs.clear_pulse_ticks  = value;
        CFG_MIN_RANGE: regs.min_range_cm       = value[RangeBits-1:0];
        CFG_MAX_RANGE: regs.max_range_cm       = value[RangeBits-1:0];
        default: ;
      endcase
    endfunction

    function cnt_t sat_inc(cnt_t v);
      return (v == cnt_t'(CounterMax)) ? v : cnt_t'(v + 1'b1);
    endfunction

    // Count one tick of a timed phase; true once the phase has run out.
    function logic phase_over(tick_t length);
      phase_cnt = sat_inc(phase_cnt);
      return (phase_cnt >= length) || (phase_cnt == cnt_t'(CounterMax));
    endfunction

    function void note_tick(uer_req_t req);
      uer_res_t    pins;
      int unsigned quot;
      pins = '0;
      case (phase)
        SEQ_IDLE: begin
          if (req.start_request) begin
            phase     = SEQ_TRIG_LOW;
            phase_cnt = '0;
          end
        end
        SEQ_TRIG_LOW: begin
          if (phase_over(regs.trigger_low_ticks)) begin
            phase     = SEQ_TRIG_HIGH;
            phase_cnt = '0;
          end
        end
        SEQ_TRIG_HIGH: begin
          pins.trigger_level = 1'b1;
          if (phase_over(regs.trigger_high_ticks)) begin
            phase     = SEQ_WAIT_ECHO;
            phase_cnt = '0;
            wait_cnt  = '0;
          end
        end
        SEQ_WAIT_ECHO: begin
          if (req.echo_level) begin
            phase     = SEQ_MEASURE;
            width_cnt = cnt_t'(1);
          end else begin
            wait_cnt = sat_inc(wait_cnt);
            if (wait_cnt > regs.echo_timeout_ticks || wait_cnt == cnt_t'(CounterMax)) begin
              phase     = SEQ_CLEAR;
              phase_cnt = '0;
            end
          end
        end
        SEQ_CLEAR: begin
          // echo is ignored for the whole pulse
          pins.echo_clear = 1'b1;
          clear_ticks++;
          wait_cnt = sat_inc(wait_cnt);
          if (phase_over(regs.clear_pulse_ticks)) begin
            phase     = SEQ_WAIT_ECHO;
            phase_cnt = '0;
          end
        end
        SEQ_MEASURE: begin
          if (req.echo_level) begin
            width_cnt = sat_inc(width_cnt);
          end else begin
            // window judged on the quotient before it is clipped to 12 bits
            quot = width_cnt / CmDivisor;
            pins.measurement_done = 1'b1;
            pins.distance_cm = (quot > DistMax) ? range_t'(DistMax) : range_t'(quot);
            pins.in_range = (quot >= regs.min_range_cm) && (quot <= regs.max_range_cm);
            phase = SEQ_IDLE;
            ranges_done++;
          end
        end
        default: phase = SEQ_IDLE;
      endcase
      expected_pins = {expected_pins, pins};
      ticks_seen++;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pins(uer_res_t got);
      uer_res_t want;
      if (expected_pins.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      want = expected_pins.pop_front();
      check_field("trigger_level", want.trigger_level, got.trigger_level);
      check_field("echo_clear", want.echo_clear, got.echo_clear);
      check_field("measurement_done", want.measurement_done, got.measurement_done);
      check_field("distance_cm", want.distance_cm, got.distance_cm);
      check_field("in_range", want.in_range, got.in_range);
    endfunction

    function int unsigned pending();
      return expected_pins.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  tick_t cfg_data_i;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  uer_req_if req_if ();
  uer_res_if res_if ();

  ultrasonic_echo_ranger dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  range_scoreboard ranger = new();

  // Idling mix of the current phase, percent of cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // --------------------------------------------------------------------------
  // Result side: sample the handshake on the pre-edge values, then pick the
  // ready for the next cycle. Runs as one process so ready has one driver.
  // --------------------------------------------------------------------------
  initial begin
    uer_res_t got;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.trigger_level    = res_if.trigger_level;
        got.echo_clear       = res_if.echo_clear;
        got.measurement_done = res_if.measurement_done;
        got.distance_cm      = res_if.distance_cm;
        got.in_range         = res_if.in_range;
        ranger.check_pins(got);
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Start bit for ticks where a start should be ignored.
  function automatic logic stray_start();
    return ($urandom_range(99) < 30);
  endfunction

  // One tick request. Called at a rising edge; returns at the edge that took
  // it, with the scoreboard already advanced. A possible idle gap comes first.
  task automatic offer_tick(logic start, logic echo);
    uer_req_t req;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid         <= 1'b1;
    req_if.start_request <= start;
    req_if.echo_level    <= echo;
    do @(posedge clk_i); while (!req_if.ready);
    req.start_request = start;
    req.echo_level    = echo;
    ranger.note_tick(req);
  endtask

  // Stop offering and wait until every result is back, plus pipeline slack.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (ranger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(uer_cfg_idx_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= tick_t'(value);
    @(posedge clk_i);
    ranger.write_reg(idx, tick_t'(value));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_ticks(int unsigned lo, int unsigned hi, int unsigned tmo,
                           int unsigned clr);
    set_reg(CFG_TRIG_LOW, lo);
    set_reg(CFG_TRIG_HIGH, hi);
    set_reg(CFG_TIMEOUT, tmo);
    set_reg(CFG_CLEAR, clr);
  endtask

  task automatic set_window(int unsigned lo_cm, int unsigned hi_cm);
    set_reg(CFG_MIN_RANGE, lo_cm);
    set_reg(CFG_MAX_RANGE, hi_cm);
  endtask

  task automatic run_until(tick_phase_e target, logic echo);
    while (ranger.phase != target) offer_tick(1'b0, echo);
  endtask

  // Drive the sequencer back to idle: raise the echo while waiting, drop it
  // once measuring.
  task automatic finish_pending();
    while (ranger.phase != SEQ_IDLE)
      offer_tick(stray_start(), ranger.phase != SEQ_MEASURE);
  endtask

  // One measurement: start, noise through the trigger phases, low_n ticks of
  // low echo, width ticks of high echo, then the falling edge.
  task automatic run_measurement(int unsigned low_n, int unsigned width);
    finish_pending();
    offer_tick(1'b1, 1'($urandom_range(1)));
    while (ranger.phase == SEQ_TRIG_LOW || ranger.phase == SEQ_TRIG_HIGH)
      offer_tick(stray_start(), 1'($urandom_range(1)));
    repeat (low_n) offer_tick(stray_start(), 1'b0);
    repeat (width) offer_tick(stray_start(), 1'b1);
    offer_tick(stray_start(), 1'b0);
    finish_pending();
  endtask

  task automatic spray_noise(int unsigned n);
    repeat (n) offer_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Short tick settings so measurements stay brief; the window is kept near
  // the few cm that short echoes give, with its extremes now and then.
  task automatic reshuffle_regs();
    int unsigned pick_lo;
    int unsigned pick_hi;
    pick_lo = $urandom_range(99);
    pick_hi = $urandom_range(99);
    set_ticks($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 12),
              $urandom_range(0, 4));
    set_window((pick_lo < 10) ? 0 : (pick_lo < 20) ? RangeMax : $urandom_range(0, 3),
               (pick_hi < 10) ? RangeMax : (pick_hi < 20) ? 0 : $urandom_range(0, 4));
  endtask

  task automatic random_measurement();
    int unsigned low_n;
    int unsigned width;
    int unsigned pick;
    if ($urandom_range(1))
      low_n = $urandom_range(0, 3);
    else
      low_n = $urandom_range(0, ranger.regs.echo_timeout_ticks
                                + 2 * ranger.regs.clear_pulse_ticks + 6);
    pick = $urandom_range(99);
    if (pick < 15)
      width = $urandom_range(1, 5);
    else if (pick < 65)
      width = $urandom_range(1, 60);
    else
      width = $urandom_range(55, 190);
    run_measurement(low_n, width);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int unsigned send_tbl [4] = '{0, 51, 0, 22};
  int unsigned recv_tbl [4] = '{0, 0, 51, 22};

  initial begin
    int unsigned mix;
    int unsigned runs;
    int unsigned tick_mark;

    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.start_request <= 1'b0;
    req_if.echo_level    <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_TRIG_LOW;
    cfg_data_i           <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: idle ticks, a start and the first ticks of the long
    // trigger low phase.
    offer_tick(1'b0, 1'b1);
    offer_tick(1'b0, 1'b0);
    offer_tick(1'b1, 1'b0);
    repeat (10) offer_tick(1'b0, 1'b0);
    settle();

    // Short tick settings, reset window kept: a 2 cm echo at its bottom edge.
    set_ticks(2, 3, 4, 3);
    run_measurement(3, 2 * CmDivisor);
    settle();

    // Quotient edges around a 0..1 cm window, then waits long enough for
    // clear pulses with the echo rising inside one.
    set_window(0, 1);
    run_measurement(0, CmDivisor);
    run_measurement(1, 2 * CmDivisor);
    run_measurement(9, 40);
    run_measurement(6, 20);
    settle();

    // Zero-valued tick registers: single-tick phases, clear after one low.
    set_ticks(0, 0, 0, 0);
    run_measurement(2, CmDivisor);
    run_measurement(0, 1);
    settle();

    // Full-scale tick registers, each one cut short by a rewrite while its
    // phase is running.
    set_reg(CFG_TRIG_LOW, TickMax);
    offer_tick(1'b1, 1'b0);
    repeat (10) offer_tick(1'b0, 1'b0);
    settle();
    set_reg(CFG_TRIG_LOW, 1);
    set_reg(CFG_TRIG_HIGH, TickMax);
    run_until(SEQ_TRIG_HIGH, 1'b0);
    repeat (10) offer_tick(1'b0, 1'b1);
    settle();
    set_reg(CFG_TRIG_HIGH, 1);
    set_reg(CFG_TIMEOUT, TickMax);
    set_reg(CFG_CLEAR, TickMax);
    run_until(SEQ_WAIT_ECHO, 1'b0);
    repeat (10) offer_tick(1'b0, 1'b0);
    settle();
    set_reg(CFG_TIMEOUT, 0);
    run_until(SEQ_CLEAR, 1'b0);
    repeat (10) offer_tick(1'b1, 1'b1);
    settle();
    set_reg(CFG_CLEAR, 1);
    run_until(SEQ_MEASURE, 1'b1);
    repeat (60) offer_tick(1'b0, 1'b1);
    offer_tick(1'b0, 1'b0);
    settle();

    // Window extremes: widest, inverted full scale, and min above max.
    set_ticks(1, 1, 3, 2);
    set_window(0, RangeMax);
    run_measurement(0, 5);
    settle();
    set_window(RangeMax, 0);
    run_measurement(0, 5);
    settle();
    set_window(1, 0);
    run_measurement(0, CmDivisor);
    settle();

    // Random measurements under each idling mix.
    for (mix = 0; mix < 4; mix++) begin
      send_idle_pct  = send_tbl[mix];
      recv_stall_pct = recv_tbl[mix];
      tick_mark = ranger.ticks_seen;
      runs = 0;
      while (ranger.ticks_seen - tick_mark < 70) begin
        if (runs % 4 == 0) begin
          settle();
          reshuffle_regs();
        end
        if ($urandom_range(99) < 12)
          spray_noise($urandom_range(5, 30));
        else
          random_measurement();
        runs++;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);

    $display("covered %0d tick requests, %0d finished measurements, %0d clear-pulse ticks",
             ranger.ticks_seen, ranger.ranges_done, ranger.clear_ticks);
    $display("over reset, zero, full-scale and random register settings; %0d mismatches",
             ranger.mismatches);
    if (ranger.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("timeout: %0d results still outstanding", ranger.pending());
    $display("FAIL");
    $finish;
  end

endmodule
